FILE: rtl/lruwb_pkg.sv
// Shared types and codes for the set-associative LRU write-back cache.
// No dependencies; every other file but lruwb_ram refers to it by scoped names.
package lruwb_pkg;

   localparam int ADDR_WIDTH = 32;

   typedef logic [ADDR_WIDTH-1:0] addr_type;

   // Request command codes
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Result kind codes
   localparam logic KIND_FETCH     = 1'b0;
   localparam logic KIND_WRITEBACK = 1'b1;

endpackage

FILE: rtl/set_assoc_lru_writeback_cache_unit.sv
// Set-associative write-back cache controller with true LRU replacement.
// Uses lruwb_pkg, lruwb_set_index and lruwb_ram.
//
// One request is handled at a time. It passes through the set index pipeline
// (reciprocal multiplies for the divide by WAYS and the wrap by SETS), then the
// synchronous read of the tag and state rows, then an update step that compares,
// updates the LRU ranks and writes the rows back. A hit returns no beat; a miss
// returns a fetch beat, preceded by a write-back beat when a dirty line is
// evicted. Results sit in an output buffer, so the next request is taken while
// they wait; it holds in its update step until the buffer has drained. After
// reset the state memory is cleared one set per cycle, and req_ready stays low
// until that pass is done.
module set_assoc_lru_writeback_cache_unit #(
   parameter int WAYS = 4,
   parameter int SETS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  lruwb_pkg::addr_type req_address,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output lruwb_pkg::addr_type rsp_line_address,
   output logic                rsp_last
);

   localparam int AW     = lruwb_pkg::ADDR_WIDTH;
   localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int RW     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int META_W = RW + 2;
   localparam logic [SW-1:0] LAST_SET  = SW'(SETS - 1);
   localparam logic [RW-1:0] OLDEST    = RW'(WAYS - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_INDEX  = 2'd2;
   localparam logic [1:0] ST_LOOKUP = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [SW-1:0]       clr_ptr_ff, clr_ptr_in;
   logic [SW-1:0]       set_ff, set_in;
   logic                cmd_ff;
   lruwb_pkg::addr_type addr_ff;
   logic                wb_valid_ff, wb_valid_in, fetch_valid_ff, fetch_valid_in;
   lruwb_pkg::addr_type wb_addr_ff, wb_addr_in, fetch_addr_ff, fetch_addr_in;

   logic                req_fire, rsp_fire, lookup_fire, rd_en;
   logic                idx_done;
   logic [SW-1:0]       idx_set;

   logic [WAYS*AW-1:0]     tag_rd_data, tag_wr_data;
   logic [WAYS*META_W-1:0] meta_rd_data, meta_wr_data, meta_new;
   logic                   meta_wr_en, tag_wr_en;
   logic [SW-1:0]          meta_wr_addr;

   logic                way_valid [WAYS];
   logic                way_dirty [WAYS];
   logic [RW-1:0]       way_rank  [WAYS];
   lruwb_pkg::addr_type way_tag   [WAYS];

   logic          hit_any, free_any, need_wb;
   logic [RW-1:0] hit_way, free_way, victim_way, sel_way, sel_rank;
   logic          sel_valid;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign rd_en       = (state_ff == ST_INDEX) && idx_done;
   assign lookup_fire = (state_ff == ST_LOOKUP) && !wb_valid_ff && !fetch_valid_ff;

   lruwb_set_index #(
      .WAYS (WAYS),
      .SETS (SETS)
   ) u_set_index (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .address   (req_address),
      .done      (idx_done),
      .set_index (idx_set)
   );

   lruwb_ram #(
      .WIDTH (WAYS * AW),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (set_ff),
      .wr_data (tag_wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_set),
      .rd_data (tag_rd_data)
   );

   lruwb_ram #(
      .WIDTH (WAYS * META_W),
      .DEPTH (SETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_set),
      .rd_data (meta_rd_data)
   );

   // Unpack the set rows into per-way fields
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_valid[w] = meta_rd_data[w*META_W + RW + 1];
         way_dirty[w] = meta_rd_data[w*META_W + RW];
         way_rank[w]  = meta_rd_data[w*META_W +: RW];
         way_tag[w]   = tag_rd_data[w*AW +: AW];
      end
   end

   // Find the hit way, the first free way and the oldest way
   always_comb begin
      hit_any    = 1'b0;
      free_any   = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      victim_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (way_valid[w] && (way_tag[w] == addr_ff)) begin
            hit_any = 1'b1;
            hit_way = RW'(w);
         end
         if (!way_valid[w]) begin
            free_any = 1'b1;
            free_way = RW'(w);
         end
         if (way_rank[w] == OLDEST) begin
            victim_way = RW'(w);
         end
      end
   end

   assign sel_way   = hit_any ? hit_way : (free_any ? free_way : victim_way);
   assign sel_valid = way_valid[sel_way];
   assign sel_rank  = way_rank[sel_way];
   assign need_wb   = !hit_any && !free_any && way_dirty[victim_way];

   // Build the updated rows: age the younger ways, refresh the chosen one
   always_comb begin
      meta_new    = meta_rd_data;
      tag_wr_data = tag_rd_data;
      for (int w = 0; w < WAYS; w++) begin
         if (RW'(w) == sel_way) begin
            meta_new[w*META_W + RW + 1] = 1'b1;
            meta_new[w*META_W + RW]     = hit_any ? (way_dirty[w] || cmd_ff) : cmd_ff;
            meta_new[w*META_W +: RW]    = '0;
            tag_wr_data[w*AW +: AW]     = addr_ff;
         end else if (way_valid[w] && (!sel_valid || (way_rank[w] < sel_rank))) begin
            meta_new[w*META_W +: RW] = way_rank[w] + RW'(1);
         end
      end
   end

   // Share the state memory write port between the clearing pass and updates
   assign meta_wr_en   = (state_ff == ST_CLEAR) || lookup_fire;
   assign meta_wr_addr = (state_ff == ST_CLEAR) ? clr_ptr_ff : set_ff;
   assign meta_wr_data = (state_ff == ST_CLEAR) ? '0 : meta_new;
   assign tag_wr_en    = lookup_fire && !hit_any;

   // Run the clearing pass, then sequence each request through index, read and update
   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      set_in     = set_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + SW'(1);
            if (clr_ptr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            if (idx_done) begin
               set_in   = idx_set;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (lookup_fire) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Load the output buffer on a miss, drop a beat when it is taken
   always_comb begin
      wb_valid_in    = wb_valid_ff;
      wb_addr_in     = wb_addr_ff;
      fetch_valid_in = fetch_valid_ff;
      fetch_addr_in  = fetch_addr_ff;
      priority if (lookup_fire) begin
         wb_valid_in    = need_wb;
         wb_addr_in     = way_tag[victim_way];
         fetch_valid_in = !hit_any;
         fetch_addr_in  = addr_ff;
      end else if (rsp_fire && wb_valid_ff) begin
         wb_valid_in = 1'b0;
      end else if (rsp_fire) begin
         fetch_valid_in = 1'b0;
      end else begin
         wb_valid_in = wb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ptr_ff     <= '0;
         wb_valid_ff    <= 1'b0;
         fetch_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ptr_ff     <= clr_ptr_in;
         wb_valid_ff    <= wb_valid_in;
         fetch_valid_ff <= fetch_valid_in;
      end
   end

   // Hold the request and result payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address;
      end
      set_ff        <= set_in;
      wb_addr_ff    <= wb_addr_in;
      fetch_addr_ff <= fetch_addr_in;
   end

   assign rsp_valid        = wb_valid_ff || fetch_valid_ff;
   assign rsp_kind         = wb_valid_ff ? lruwb_pkg::KIND_WRITEBACK : lruwb_pkg::KIND_FETCH;
   assign rsp_line_address = wb_valid_ff ? wb_addr_ff : fetch_addr_ff;
   assign rsp_last         = !wb_valid_ff;

endmodule

FILE: rtl/lruwb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lruwb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lruwb_set_index.sv
// Set index pipeline: set = (address / WAYS) mod SETS in three stages.
// Uses lruwb_pkg for the address type.
module lruwb_set_index #(
   parameter int WAYS = 4,
   parameter int SETS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  lruwb_pkg::addr_type                  address,
   output logic                                 done,
   output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_index
);

   localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int CELLS = WAYS * SETS;

   // Reciprocals floor(2^32 / d); the estimate is low by at most one
   localparam logic [63:0] RECIP_W_WIDE = (64'd1 << 32) / 64'(WAYS);
   localparam logic [63:0] RECIP_C_WIDE = (64'd1 << 32) / 64'(CELLS);
   localparam logic [31:0] RECIP_W = RECIP_W_WIDE[31:0];
   localparam logic [31:0] RECIP_C = RECIP_C_WIDE[31:0];
   localparam logic [31:0] WAYS_U  = 32'(WAYS);
   localparam logic [31:0] CELLS_U = 32'(CELLS);
   localparam logic [31:0] SETS_U  = 32'(SETS);

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   lruwb_pkg::addr_type s1_addr_ff;
   logic [31:0]         s1_qw_ff, s1_qc_ff, s1_qw_in, s1_qc_in;
   logic [31:0]         s2_qw_ff, s2_qc_ff, s2_qw_in, s2_qc_in;
   logic [SW-1:0]       s3_set_ff, s3_set_in;
   logic [63:0]         prod_w, prod_c;
   logic [31:0]         rem_w, rem_c;
   logic [SW-1:0]       wrap_term;

   // Stage 1: quotient estimates by reciprocal multiply
   assign prod_w   = {32'd0, address} * {32'd0, RECIP_W};
   assign prod_c   = {32'd0, address} * {32'd0, RECIP_C};
   assign s1_qw_in = (WAYS == 1) ? address : prod_w[63:32];
   assign s1_qc_in = (CELLS == 1) ? address : prod_c[63:32];

   // Stage 2: correct each estimate with one compare
   assign rem_w    = s1_addr_ff - s1_qw_ff * WAYS_U;
   assign rem_c    = s1_addr_ff - s1_qc_ff * CELLS_U;
   assign s2_qw_in = (rem_w >= WAYS_U) ? s1_qw_ff + 32'd1 : s1_qw_ff;
   assign s2_qc_in = (rem_c >= CELLS_U) ? s1_qc_ff + 32'd1 : s1_qc_ff;

   // Stage 3: floor(a/W) - floor(a/(W*S))*S, low bits only
   assign wrap_term = s2_qc_ff[SW-1:0] * SETS_U[SW-1:0];
   assign s3_set_in = s2_qw_ff[SW-1:0] - wrap_term;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Advance the data
   always_ff @(posedge clock) begin
      s1_addr_ff <= address;
      s1_qw_ff   <= s1_qw_in;
      s1_qc_ff   <= s1_qc_in;
      s2_qw_ff   <= s2_qw_in;
      s2_qc_ff   <= s2_qc_in;
      s3_set_ff  <= s3_set_in;
   end

   assign done      = s3_valid_ff;
   assign set_index = s3_set_ff;

endmodule

FILE: verif/tb_set_assoc_lru_writeback_cache_unit.sv
`timescale 1ns / 1ps
// Testbench for set_assoc_lru_writeback_cache_unit: a directed table, then random traffic,
// every beat checked against typed row markers or a model of tags, valid/dirty bits, LRU.
// Depends on lruwb_pkg and the cache unit RTL.
module tb_set_assoc_lru_writeback_cache_unit;

   localparam int WAYS         = 4;
   localparam int SETS         = 8;
   localparam int LINES        = WAYS * SETS;
   localparam int RANK_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NUM_DIRECTED = 20;
   localparam int RANDOM_ITEMS = 700;
   localparam int TAIL_ITEMS   = 100;
   localparam int POOL_SIZE    = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;

   // Directed row markers
   localparam logic TYPED   = 1'b1;
   localparam logic CHECKED = 1'b0;
   localparam logic HIT     = 1'b1;
   localparam logic MISS    = 1'b0;

   typedef struct packed {
      logic                kind;
      lruwb_pkg::addr_type line_address;
      logic                last;
   } cache_beat_type;

   typedef struct packed {
      logic                command;
      lruwb_pkg::addr_type address;
      logic                typed;
      logic                hit;
   } stim_row_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_command = lruwb_pkg::CMD_READ;
   lruwb_pkg::addr_type req_address = '0;
   logic                rsp_ready   = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic                rsp_kind;
   lruwb_pkg::addr_type rsp_line_address;
   logic                rsp_last;

   // Model of the cache contents
   lruwb_pkg::addr_type line_tag   [LINES];
   logic                line_valid [LINES];
   logic                line_dirty [LINES];
   logic [RANK_W-1:0]   line_rank  [LINES];

   cache_beat_type pending_beats [$];
   cache_beat_type got_beat;
   cache_beat_type want_beat;
   stim_row_type   directed [NUM_DIRECTED];
   int             error_count = 0;
   int             cycle_count = 0;
   int             stall_left  = 0;
   bit             quiet_tail  = 1'b0;

   set_assoc_lru_writeback_cache_unit #(
      .WAYS(WAYS),
      .SETS(SETS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_line_address(rsp_line_address),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void log_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // Make one way of a set the most recent; age the ways that were younger.
   function automatic void promote_way(int base, int way);
      logic              was_valid;
      logic [RANK_W-1:0] old_rank;
      was_valid = line_valid[base + way];
      old_rank  = line_rank[base + way];
      for (int w = 0; w < WAYS; w++) begin
         if (w != way && line_valid[base + w] &&
             (!was_valid || line_rank[base + w] < old_rank))
            line_rank[base + w] = line_rank[base + w] + 1'b1;
      end
      line_rank[base + way] = '0;
   endfunction

   // Apply one request to the model; queue its beats when record is set.
   function automatic void cache_access(logic command, lruwb_pkg::addr_type address,
                                        bit record);
      int unsigned       set_idx;
      int                base;
      int                way;
      logic [RANK_W-1:0] oldest;
      set_idx = (address / WAYS) % SETS;
      base    = set_idx * WAYS;

      // Hit: refresh, mark dirty on a write, no beat
      for (int w = 0; w < WAYS; w++) begin
         if (line_valid[base + w] && line_tag[base + w] == address) begin
            if (command == lruwb_pkg::CMD_WRITE)
               line_dirty[base + w] = 1'b1;
            promote_way(base, w);
            return;
         end
      end

      // Miss: first free way, else the oldest one
      way = WAYS;
      for (int w = 0; w < WAYS; w++) begin
         if (!line_valid[base + w] && way == WAYS)
            way = w;
      end
      if (way == WAYS) begin
         oldest = '0;
         way    = 0;
         for (int w = 0; w < WAYS; w++) begin
            if (line_rank[base + w] > oldest) begin
               oldest = line_rank[base + w];
               way    = w;
            end
         end
         if (line_dirty[base + way] && record)
            pending_beats.push_back(cache_beat_type'{lruwb_pkg::KIND_WRITEBACK,
                                                     line_tag[base + way], 1'b0});
      end

      promote_way(base, way);
      line_tag[base + way]   = address;
      line_valid[base + way] = 1'b1;
      line_dirty[base + way] = (command == lruwb_pkg::CMD_WRITE);
      if (record)
         pending_beats.push_back(cache_beat_type'{lruwb_pkg::KIND_FETCH, address, 1'b1});
   endfunction

   // Drive one request beat, with an optional idle burst ahead of it.
   task automatic send_req(input logic command, input lruwb_pkg::addr_type address,
                           input bit record);
      int gap;
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= command;
      req_address <= address;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      cache_access(command, address, record);
   endtask

   // Stall the result side in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_beat = cache_beat_type'{rsp_kind, rsp_line_address, rsp_last};
         if (pending_beats.size() == 0) begin
            log_failure($sformatf("expected no beat, got kind=%0d addr=%h last=%0d",
                                  got_beat.kind, got_beat.line_address, got_beat.last));
         end else begin
            want_beat = pending_beats.pop_front();
            if (got_beat.kind !== want_beat.kind ||
                got_beat.line_address !== want_beat.line_address ||
                got_beat.last !== want_beat.last)
               log_failure($sformatf(
                  "beat mismatch: expected kind=%0d addr=%h last=%0d, got kind=%0d addr=%h last=%0d",
                  want_beat.kind, want_beat.line_address, want_beat.last,
                  got_beat.kind, got_beat.line_address, got_beat.last));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_set_assoc_lru_writeback_cache_unit: done, errors");
         $finish;
      end
   end

   initial begin
      lruwb_pkg::addr_type pool [POOL_SIZE];
      lruwb_pkg::addr_type address;
      logic                command;
      stim_row_type        row;

      for (int i = 0; i < LINES; i++) begin
         line_tag[i]   = '0;
         line_valid[i] = 1'b0;
         line_dirty[i] = 1'b0;
         line_rank[i]  = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++)
         pool[i] = $urandom;

      // Fills, hits and evictions in set 0 and in set 7, which holds the all-ones address
      directed = '{
         '{lruwb_pkg::CMD_WRITE, 32'h0000_0000, TYPED,   MISS},
         '{lruwb_pkg::CMD_READ,  32'h0000_0000, TYPED,   HIT },
         '{lruwb_pkg::CMD_WRITE, 32'hFFFF_FFFF, TYPED,   MISS},
         '{lruwb_pkg::CMD_READ,  32'hFFFF_FFFF, TYPED,   HIT },
         '{lruwb_pkg::CMD_READ,  32'h0000_0001, TYPED,   MISS},
         '{lruwb_pkg::CMD_WRITE, 32'h0000_0002, TYPED,   MISS},
         '{lruwb_pkg::CMD_READ,  32'h0000_0003, TYPED,   MISS},
         // read miss evicting a dirty line; new line must start clean
         '{lruwb_pkg::CMD_READ,  32'hFFFF_FFE0, CHECKED, MISS},
         '{lruwb_pkg::CMD_WRITE, 32'h0000_0001, CHECKED, HIT },
         '{lruwb_pkg::CMD_WRITE, 32'h0000_0020, CHECKED, MISS},
         '{lruwb_pkg::CMD_READ,  32'h0000_0040, CHECKED, MISS},
         '{lruwb_pkg::CMD_READ,  32'h0000_0060, CHECKED, MISS},
         '{lruwb_pkg::CMD_READ,  32'h0000_0080, CHECKED, MISS},
         '{lruwb_pkg::CMD_WRITE, 32'hFFFF_FFFF, CHECKED, HIT },
         '{lruwb_pkg::CMD_WRITE, 32'h7FFF_FFFC, CHECKED, MISS},
         '{lruwb_pkg::CMD_WRITE, 32'h8000_001F, CHECKED, MISS},
         '{lruwb_pkg::CMD_WRITE, 32'h5555_555F, CHECKED, MISS},
         '{lruwb_pkg::CMD_READ,  32'hAAAA_AABC, CHECKED, MISS},
         '{lruwb_pkg::CMD_READ,  32'h7FFF_FFFC, CHECKED, HIT },
         '{lruwb_pkg::CMD_WRITE, 32'h0000_0000, CHECKED, MISS}
      };

      // Hold reset, then release it on a falling clock edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed[i];
         send_req(row.command, row.address, !row.typed);
         if (row.typed && !row.hit)
            pending_beats.push_back(cache_beat_type'{lruwb_pkg::KIND_FETCH, row.address,
                                                     1'b1});
      end

      // Random traffic over a small address pool so sets contend
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet_tail = (i >= RANDOM_ITEMS - TAIL_ITEMS);
         if ($urandom_range(0, 99) < 10)
            pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
         if ($urandom_range(0, 99) < 85)
            address = pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            address = $urandom;
         command = 1'($urandom_range(0, 1));
         send_req(command, address, 1'b1);
      end

      // Drop valid and drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_beats.size() == 0)
         $display("tb_set_assoc_lru_writeback_cache_unit: done, clean");
      else
         $display("tb_set_assoc_lru_writeback_cache_unit: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lruwb_pkg.sv
rtl/lruwb_ram.sv
rtl/lruwb_set_index.sv
rtl/set_assoc_lru_writeback_cache_unit.sv
verif/tb_set_assoc_lru_writeback_cache_unit.sv
